@@ rtl/sgbr_pkg.sv @@
// ----------------------------------------------------------------------------
// sgbr_pkg: shared types and constants for the scaled glyph box renderer
// Field widths, font geometry, controller/datapath command and status types
// and the 6x8 column font.
// ----------------------------------------------------------------------------
package sgbr_pkg;

    localparam int CODE_W        = 8;
    localparam int POS_W         = 8;
    localparam int SCALE_W       = 4;
    localparam int COORD_W       = 9;
    localparam int GLYPH_COLUMNS = 6;
    localparam int GLYPH_ROWS    = 8;
    localparam int GLYPH_BITS    = GLYPH_COLUMNS * GLYPH_ROWS;
    localparam int ROW_W         = $clog2(GLYPH_ROWS);
    localparam int MAX_SCALE     = 8;

    typedef logic [GLYPH_BITS-1:0] t_glyph;

    typedef struct packed {
        logic load;   // request accepted, set up a new character
        logic step;   // scan one glyph bit
    } t_dp_cmd;

    typedef struct packed {
        logic bit_set;     // current glyph bit is a pixel
        logic rest_empty;  // no pixel after the current bit
        logic slot_free;   // output register can take a box this cycle
    } t_dp_sts;

    // Glyph columns packed with column 0 in the low byte; bit r of a column
    // is row r (row 0 on top). Unknown codes give an empty glyph.
    function automatic t_glyph font_bits(input logic [CODE_W-1:0] code);
        t_glyph g;
        g = '0;
        case (code)
            8'h30: g = 48'h00_3E_45_49_51_3E; // 0
            8'h31: g = 48'h00_00_40_7F_42_00; // 1
            8'h32: g = 48'h00_46_49_51_61_42; // 2
            8'h33: g = 48'h00_31_4B_45_41_21; // 3
            8'h34: g = 48'h00_10_7F_12_14_18; // 4
            8'h35: g = 48'h00_39_45_45_45_27; // 5
            8'h36: g = 48'h00_30_49_49_4A_3C; // 6
            8'h37: g = 48'h00_03_05_09_71_01; // 7
            8'h38: g = 48'h00_36_49_49_49_36; // 8
            8'h39: g = 48'h00_1E_29_49_49_06; // 9
            8'h2E: g = 48'h00_00_60_60_00_00; // .
            8'h64: g = 48'h00_00_06_09_09_06; // degree mark
            8'h25: g = 48'h00_23_13_08_64_62; // %
            8'h2D: g = 48'h00_08_08_08_08_08; // -
            8'h54: g = 48'h00_01_01_7F_01_01; // T
            8'h48: g = 48'h00_7F_08_08_08_7F; // H
            8'h45: g = 48'h00_41_49_49_49_7F; // E
            8'h4D: g = 48'h00_7F_02_04_02_7F; // M
            8'h50: g = 48'h00_06_09_09_09_7F; // P
            8'h55: g = 48'h00_3F_40_40_40_3F; // U
            8'h49: g = 48'h00_00_41_7F_41_00; // I
            8'h44: g = 48'h00_1C_22_41_41_7F; // D
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

@@ rtl/sgbr_if.sv @@
// ----------------------------------------------------------------------------
// sgbr_if: request and box channels of the glyph box renderer
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface sgbr_in_if;
    logic                         valid;
    logic                         ready;
    logic [sgbr_pkg::CODE_W-1:0]  char_code;
    logic                         start_string;
    logic [sgbr_pkg::POS_W-1:0]   pos_x;
    logic [sgbr_pkg::POS_W-1:0]   pos_y;
    logic [sgbr_pkg::SCALE_W-1:0] scale;

    modport source (output valid, char_code, start_string, pos_x, pos_y, scale,
                    input ready);
    modport sink   (input valid, char_code, start_string, pos_x, pos_y, scale,
                    output ready);
endinterface

interface sgbr_out_if;
    logic                         valid;
    logic                         ready;
    logic [sgbr_pkg::COORD_W-1:0] box_x;
    logic [sgbr_pkg::COORD_W-1:0] box_y;
    logic [sgbr_pkg::SCALE_W-1:0] box_size;
    logic                         last_box;

    modport source (output valid, box_x, box_y, box_size, last_box, input ready);
    modport sink   (input valid, box_x, box_y, box_size, last_box, output ready);
endinterface

@@ rtl/sgbr_ctrl.sv @@
// ----------------------------------------------------------------------------
// sgbr_ctrl: sequencer of the glyph box renderer
// Takes one request at a time and steps the datapath through the glyph bits.
// ----------------------------------------------------------------------------
module sgbr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sgbr_pkg::t_dp_sts i_sts,
    output sgbr_pkg::t_dp_cmd o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic r_state;
    logic n_state;

    assign o_in_ready = (r_state == ST_IDLE);
    assign o_cmd.load = o_in_ready && i_in_valid;
    // a pixel waits while the output register is still full
    assign o_cmd.step = (r_state == ST_SCAN) && (!i_sts.bit_set || i_sts.slot_free);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (o_cmd.step && i_sts.rest_empty) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/sgbr_dpath.sv @@
// ----------------------------------------------------------------------------
// sgbr_dpath: datapath of the glyph box renderer
// Cursor, glyph shift register, box coordinate accumulators, output register.
// ----------------------------------------------------------------------------
module sgbr_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sgbr_pkg::t_dp_cmd            i_cmd,
    output sgbr_pkg::t_dp_sts            o_sts,
    input  logic [sgbr_pkg::CODE_W-1:0]  i_char_code,
    input  logic                         i_start_string,
    input  logic [sgbr_pkg::POS_W-1:0]   i_pos_x,
    input  logic [sgbr_pkg::POS_W-1:0]   i_pos_y,
    input  logic [sgbr_pkg::SCALE_W-1:0] i_scale,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [sgbr_pkg::COORD_W-1:0] o_box_x,
    output logic [sgbr_pkg::COORD_W-1:0] o_box_y,
    output logic [sgbr_pkg::SCALE_W-1:0] o_box_size,
    output logic                         o_last_box
);

    localparam int ADV_W = sgbr_pkg::SCALE_W + 3;

    logic [sgbr_pkg::POS_W-1:0]   r_cur_x;
    logic [sgbr_pkg::POS_W-1:0]   r_cur_y;
    logic [sgbr_pkg::POS_W-1:0]   r_base_y;
    logic [sgbr_pkg::SCALE_W-1:0] r_scale;
    sgbr_pkg::t_glyph             r_bits;
    logic [sgbr_pkg::ROW_W-1:0]   r_row;
    logic [sgbr_pkg::COORD_W-1:0] r_col_x;
    logic [sgbr_pkg::COORD_W-1:0] r_row_y;
    logic                         r_out_valid;
    logic [sgbr_pkg::COORD_W-1:0] r_box_x;
    logic [sgbr_pkg::COORD_W-1:0] r_box_y;
    logic [sgbr_pkg::SCALE_W-1:0] r_box_size;
    logic                         r_last_box;

    logic [sgbr_pkg::POS_W-1:0]   w_base_x;
    logic [sgbr_pkg::POS_W-1:0]   w_base_y;
    logic [sgbr_pkg::SCALE_W-1:0] w_eff_scale;
    logic [ADV_W-1:0]             w_advance;
    logic                         w_emit;

    always_comb begin
        if (i_scale == '0) begin
            w_eff_scale = sgbr_pkg::SCALE_W'(1);
        end else if ({1'b0, i_scale} > (sgbr_pkg::SCALE_W + 1)'(sgbr_pkg::MAX_SCALE)) begin
            w_eff_scale = sgbr_pkg::SCALE_W'(sgbr_pkg::MAX_SCALE);
        end else begin
            w_eff_scale = i_scale;
        end
    end

    assign w_base_x  = i_start_string ? i_pos_x : r_cur_x;
    assign w_base_y  = i_start_string ? i_pos_y : r_cur_y;
    // six columns: 4*scale + 2*scale
    assign w_advance = {1'b0, w_eff_scale, 2'b00} + {2'b00, w_eff_scale, 1'b0};

    assign o_sts.bit_set    = r_bits[0];
    assign o_sts.rest_empty = (r_bits[sgbr_pkg::GLYPH_BITS-1:1] == '0);
    assign o_sts.slot_free  = !r_out_valid || i_out_ready;

    assign w_emit = i_cmd.step && r_bits[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x <= '0;
            r_cur_y <= '0;
        end else if (i_cmd.load) begin
            r_cur_x <= w_base_x + sgbr_pkg::POS_W'(w_advance);
            r_cur_y <= w_base_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_scale  <= w_eff_scale;
            r_bits   <= sgbr_pkg::font_bits(i_char_code);
            r_row    <= '0;
            r_base_y <= w_base_y;
            r_col_x  <= {1'b0, w_base_x};
            r_row_y  <= {1'b0, w_base_y};
        end else if (i_cmd.step) begin
            r_bits <= r_bits >> 1;
            if (r_row == sgbr_pkg::ROW_W'(sgbr_pkg::GLYPH_ROWS - 1)) begin
                r_row   <= '0;
                r_col_x <= r_col_x + sgbr_pkg::COORD_W'(r_scale);
                r_row_y <= {1'b0, r_base_y};
            end else begin
                r_row   <= r_row + 1'b1;
                r_row_y <= r_row_y + sgbr_pkg::COORD_W'(r_scale);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_box_x    <= r_col_x;
            r_box_y    <= r_row_y;
            r_box_size <= r_scale;
            r_last_box <= o_sts.rest_empty;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_box_x     = r_box_x;
    assign o_box_y     = r_box_y;
    assign o_box_size  = r_box_size;
    assign o_last_box  = r_last_box;

endmodule

@@ rtl/scaled_glyph_box_renderer.sv @@
// ----------------------------------------------------------------------------
// scaled_glyph_box_renderer: draws one character as scaled pixel boxes
// Timing: a box is in the output register in the cycle after its glyph bit
//   is scanned; the first scan cycle follows the request cycle.
// Throughput: one request at a time; the next is taken once the last set
//   glyph bit has been scanned. The 48-bit glyph shift register is scanned
//   one bit a cycle while no pixel waits on a full output register.
// Stall: a pixel waits while the output register holds an untaken box.
// Reset: cursor goes to (0, 0), channels idle, no box pending.
// ----------------------------------------------------------------------------
module scaled_glyph_box_renderer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sgbr_in_if.sink      i_in,
    sgbr_out_if.source   o_out
);

    sgbr_pkg::t_dp_cmd w_cmd;
    sgbr_pkg::t_dp_sts w_sts;
    logic              w_in_ready;

    sgbr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    sgbr_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_char_code    (i_in.char_code),
        .i_start_string (i_in.start_string),
        .i_pos_x        (i_in.pos_x),
        .i_pos_y        (i_in.pos_y),
        .i_scale        (i_in.scale),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_box_x        (o_out.box_x),
        .o_box_y        (o_out.box_y),
        .o_box_size     (o_out.box_size),
        .o_last_box     (o_out.last_box)
    );

    assign i_in.ready = w_in_ready;

    // a pixel is never scanned over a box that has not been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.step && w_sts.bit_set) |-> w_sts.slot_free)
        else $error("box overwritten in output register");

    // one request at a time
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("request taken while a character is in progress");

    // scanning the final bit frees the request side
    a_idle_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.step && w_sts.rest_empty) |=> i_in.ready)
        else $error("sequencer did not return to idle");

    // a box emitted while set glyph bits remain after it is never marked last
    a_last_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.step && w_sts.bit_set && !w_sts.rest_empty) |=> !o_out.last_box)
        else $error("box marked last before end of glyph");

    a_size_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.box_size != '0))
        else $error("box of zero size");

endmodule

@@ verif/tb_scaled_glyph_box_renderer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scaled_glyph_box_renderer: self-checking bench for the glyph box renderer
// Requests come from a queue filled up front: a directed pass over every
// glyph, the scale clamps, the position extremes and unknown codes, then
// random strings with some noise. A behavioral model of the font scan and
// text cursor predicts every box. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_scaled_glyph_box_renderer;

    localparam int CODE_W        = sgbr_pkg::CODE_W;
    localparam int POS_W         = sgbr_pkg::POS_W;
    localparam int SCALE_W       = sgbr_pkg::SCALE_W;
    localparam int COORD_W       = sgbr_pkg::COORD_W;
    localparam int GLYPH_COLUMNS = sgbr_pkg::GLYPH_COLUMNS;
    localparam int GLYPH_ROWS    = sgbr_pkg::GLYPH_ROWS;
    localparam int MAX_SCALE     = sgbr_pkg::MAX_SCALE;

    localparam int GLYPH_COUNT   = 22;
    localparam int RANDOM_REQS   = 325;
    localparam int SEND_LONG_GAP = 60;
    localparam int RECV_LONG_GAP = 20;
    localparam int TAIL_CYCLES   = 60;
    localparam int CYCLE_LIMIT   = 1_500_000;

    localparam logic [CODE_W-1:0] CODE_NUL   = 8'h00;
    localparam logic [CODE_W-1:0] CODE_SPACE = 8'h20;
    localparam logic [CODE_W-1:0] CODE_ALL1  = 8'hFF;

    typedef struct {
        logic [CODE_W-1:0]  char_code;
        logic               start_string;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [SCALE_W-1:0] scale;
        logic               drain_first;  // hold the request until all boxes are in
    } t_glyph_req;

    typedef struct {
        logic [COORD_W-1:0] box_x;
        logic [COORD_W-1:0] box_y;
        logic [SCALE_W-1:0] box_size;
        logic               last_box;
    } t_box;

    // character codes in font order
    localparam logic [CODE_W-1:0] GLYPH_CODES [GLYPH_COUNT] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
        8'h2E, 8'h64, 8'h25, 8'h2D, 8'h54, 8'h48, 8'h45, 8'h4D, 8'h50, 8'h55,
        8'h49, 8'h44
    };

    // one byte per column, bit r is row r
    localparam logic [7:0] FONT_COLS [GLYPH_COUNT][GLYPH_COLUMNS] = '{
        '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E, 8'h00},
        '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00, 8'h00},
        '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46, 8'h00},
        '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31, 8'h00},
        '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10, 8'h00},
        '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39, 8'h00},
        '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30, 8'h00},
        '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03, 8'h00},
        '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36, 8'h00},
        '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E, 8'h00},
        '{8'h00, 8'h00, 8'h60, 8'h60, 8'h00, 8'h00},
        '{8'h06, 8'h09, 8'h09, 8'h06, 8'h00, 8'h00},
        '{8'h62, 8'h64, 8'h08, 8'h13, 8'h23, 8'h00},
        '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08, 8'h00},
        '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01, 8'h00},
        '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F, 8'h00},
        '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41, 8'h00},
        '{8'h7F, 8'h02, 8'h04, 8'h02, 8'h7F, 8'h00},
        '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06, 8'h00},
        '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F, 8'h00},
        '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00, 8'h00},
        '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C, 8'h00}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    sgbr_in_if  req_if ();
    sgbr_out_if box_if ();

    scaled_glyph_box_renderer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (box_if)
    );

    t_glyph_req pending_reqs [$];
    t_box       expected_boxes [$];
    t_glyph_req cur_req;
    t_box       want_box;
    logic [POS_W-1:0] pen_x;
    logic [POS_W-1:0] pen_y;
    int total_reqs;
    int reqs_taken;
    int mismatches;
    int send_gap;
    int send_calm;
    int recv_stall;
    int recv_calm;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mostly no gap, some short, a few long; occasional gap-free stretches
    function automatic int idle_len(inout int calm_left, input int long_max);
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(8, long_max);
    endfunction

    function automatic int glyph_index(input logic [CODE_W-1:0] code);
        for (int g = 0; g < GLYPH_COUNT; g++)
            if (GLYPH_CODES[g] == code) return g;
        return -1;
    endfunction

    // cursor update plus box list for one accepted request
    task automatic predict_glyph_boxes(input t_glyph_req r);
        int   g;
        int   sc;
        bit   any;
        t_box b;
        any = 1'b0;
        if (r.start_string) begin
            pen_x = r.pos_x;
            pen_y = r.pos_y;
        end
        sc = (r.scale == 0) ? 1 : ((r.scale > MAX_SCALE) ? MAX_SCALE : int'(r.scale));
        g = glyph_index(r.char_code);
        if (g >= 0) begin
            for (int col = 0; col < GLYPH_COLUMNS; col++) begin
                for (int row = 0; row < GLYPH_ROWS; row++) begin
                    if (FONT_COLS[g][col][row]) begin
                        b.box_x    = COORD_W'(int'(pen_x) + col * sc);
                        b.box_y    = COORD_W'(int'(pen_y) + row * sc);
                        b.box_size = SCALE_W'(sc);
                        b.last_box = 1'b0;
                        expected_boxes.push_back(b);
                        any = 1'b1;
                    end
                end
            end
        end
        if (any) expected_boxes[expected_boxes.size() - 1].last_box = 1'b1;
        pen_x = POS_W'(int'(pen_x) + GLYPH_COLUMNS * sc);
    endtask

    task automatic add_req(input logic [CODE_W-1:0] code, input logic start,
                           input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                           input logic [SCALE_W-1:0] sc, input logic drain);
        t_glyph_req r;
        r.char_code    = code;
        r.start_string = start;
        r.pos_x        = x;
        r.pos_y        = y;
        r.scale        = sc;
        r.drain_first  = drain;
        pending_reqs.push_back(r);
    endtask

    function automatic logic [SCALE_W-1:0] pick_scale();
        if ($urandom_range(0, 99) < 85) return SCALE_W'($urandom_range(1, MAX_SCALE));
        return ($urandom_range(0, 1) == 0) ? SCALE_W'(0)
                                           : SCALE_W'($urandom_range(MAX_SCALE + 1, 15));
    endfunction

    task automatic check_field(input string name, input logic [COORD_W-1:0] want,
                               input logic [COORD_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            send_gap     = 0;
        end else begin
            if (!(req_if.valid && !req_if.ready)) begin
                if (req_if.valid && req_if.ready) begin
                    predict_glyph_boxes(cur_req);
                    reqs_taken++;
                end
                if (send_gap > 0) begin
                    send_gap--;
                    req_if.valid <= 1'b0;
                end else if (pending_reqs.size() > 0 &&
                             !(pending_reqs[0].drain_first && expected_boxes.size() != 0)) begin
                    cur_req = pending_reqs.pop_front();
                    req_if.char_code    <= cur_req.char_code;
                    req_if.start_string <= cur_req.start_string;
                    req_if.pos_x        <= cur_req.pos_x;
                    req_if.pos_y        <= cur_req.pos_y;
                    req_if.scale        <= cur_req.scale;
                    req_if.valid        <= 1'b1;
                    send_gap = idle_len(send_calm, SEND_LONG_GAP);
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // box monitor and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            box_if.ready <= 1'b0;
            recv_stall   = 0;
        end else begin
            if (box_if.valid && box_if.ready) begin
                if (expected_boxes.size() == 0) begin
                    $error("unexpected box: box_x %0d box_y %0d box_size %0d last_box %0d",
                           box_if.box_x, box_if.box_y, box_if.box_size, box_if.last_box);
                    mismatches++;
                end else begin
                    want_box = expected_boxes.pop_front();
                    check_field("box_x", want_box.box_x, box_if.box_x);
                    check_field("box_y", want_box.box_y, box_if.box_y);
                    check_field("box_size", COORD_W'(want_box.box_size),
                                COORD_W'(box_if.box_size));
                    check_field("last_box", COORD_W'(want_box.last_box),
                                COORD_W'(box_if.last_box));
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                box_if.ready <= 1'b0;
            end else begin
                box_if.ready <= 1'b1;
                recv_stall = idle_len(recv_calm, RECV_LONG_GAP);
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("scaled_glyph_box_renderer verification failed");
        $finish;
    end

    initial begin
        int made;
        int len;
        logic [SCALE_W-1:0] sc;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [CODE_W-1:0] code;

        i_rst_n             = 1'b0;
        req_if.valid        = 1'b0;
        req_if.char_code    = '0;
        req_if.start_string = 1'b0;
        req_if.pos_x        = '0;
        req_if.pos_y        = '0;
        req_if.scale        = '0;
        box_if.ready        = 1'b0;
        pen_x       = '0;
        pen_y       = '0;
        reqs_taken  = 0;
        mismatches  = 0;
        send_calm   = 0;
        recv_calm   = 0;

        // every glyph once; scale sweeps 0..15 so both clamps are hit
        for (int i = 0; i < GLYPH_COUNT; i++) begin
            x = (i == 0) ? 8'h00 : (i == 4) ? 8'hFF : POS_W'($urandom);
            y = (i == 0) ? 8'h00 : (i == 4) ? 8'hFF : POS_W'($urandom);
            add_req(GLYPH_CODES[i], (i % 4) == 0, x, y, SCALE_W'(i % 16), 1'b0);
        end
        // unknown codes draw nothing but still move the cursor
        add_req(CODE_NUL, 1'b0, 8'hFF, 8'h00, SCALE_W'(MAX_SCALE), 1'b0);
        add_req(CODE_SPACE, 1'b0, 8'h00, 8'hFF, 4'hF, 1'b0);
        add_req(CODE_ALL1, 1'b0, 8'hFF, 8'hFF, SCALE_W'(MAX_SCALE), 1'b0);

        // random strings, with stray requests mixed in
        made = 0;
        while (made < RANDOM_REQS) begin
            if ($urandom_range(0, 99) < 15) begin
                add_req(CODE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                        POS_W'($urandom), POS_W'($urandom), SCALE_W'($urandom_range(0, 15)),
                        made == 0);
                made++;
            end else begin
                len = $urandom_range(1, 8);
                sc  = pick_scale();
                x   = POS_W'($urandom);
                y   = POS_W'($urandom);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 9) == 0) code = CODE_SPACE;
                    else code = GLYPH_CODES[$urandom_range(0, GLYPH_COUNT - 1)];
                    if ($urandom_range(0, 19) == 0) sc = pick_scale();
                    // pos fields are random even when ignored
                    add_req(code, k == 0, (k == 0) ? x : POS_W'($urandom),
                            (k == 0) ? y : POS_W'($urandom), sc,
                            (made == 0) || (k == 0 && $urandom_range(0, 29) == 0));
                    made++;
                end
            end
        end
        total_reqs = pending_reqs.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (reqs_taken < total_reqs) @(posedge i_clk);
        while (expected_boxes.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("scaled_glyph_box_renderer verification clean");
        else
            $display("scaled_glyph_box_renderer verification failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/sgbr_pkg.sv
rtl/sgbr_if.sv
rtl/sgbr_ctrl.sv
rtl/sgbr_dpath.sv
rtl/scaled_glyph_box_renderer.sv
verif/tb_scaled_glyph_box_renderer.sv
